// File: rtl/rsa_mexp_pkg.sv
package rsa_mexp_pkg;

  // Port width of values and configuration data
  localparam int DATA_W = 16;
  // Default arithmetic width
  localparam int WIDTH_DEF = 16;
  // Configuration register index width
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS  = 2'd0,
    REG_PUB_EXP  = 2'd1,
    REG_PRIV_EXP = 2'd2
  } cfg_reg_t;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

endpackage

// File: rtl/rsa_mexp_mulmod.sv
// Bit-serial modular multiplier: scans the multiplier MSB first,
// one bit per cycle (double, conditionally add, reduce).
module rsa_mexp_mulmod #(
  parameter int WIDTH = rsa_mexp_pkg::WIDTH_DEF,
  localparam int MW = (WIDTH > rsa_mexp_pkg::DATA_W) ? WIDTH : rsa_mexp_pkg::DATA_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [MW-1:0]    b_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  localparam int TW = WIDTH + 2;
  localparam int CW = $clog2(MW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [MW-1:0]    mplier_r, mplier_nxt;

  logic [TW-1:0] sum, m1, m2, red;

  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + (mplier_r[MW-1] ? {2'b00, a_r} : {TW{1'b0}});
    m1  = {2'b00, m_r};
    m2  = {1'b0, m_r, 1'b0};
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    a_nxt      = a_r;
    m_nxt      = m_r;
    mplier_nxt = mplier_r;
    if (start_i) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = CW'(MW);
      acc_nxt    = '0;
      a_nxt      = a_i;
      m_nxt      = m_i;
      mplier_nxt = b_i;
    end else if (busy_r) begin
      acc_nxt    = red[WIDTH-1:0];
      mplier_nxt = {mplier_r[MW-2:0], 1'b0};
      cnt_nxt    = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    a_r      <= a_nxt;
    m_r      <= m_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done_o = done_r;
  assign prod_o = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r)
    else $error("multiplier started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("multiplier done while still busy");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("multiplier busy with no bits left");

endmodule

// File: rtl/rsa_modular_exponentiation.sv
// Channel  | Ports                                   | Flow
// ---------+-----------------------------------------+---------------------------
// input    | start, busy, in_op, in_value            | taken when start && !busy
// result   | out_valid, out_result_value             | one-cycle strobe, no stall
// config   | cfg_we, cfg_index, cfg_data             | written when cfg_we
//
// One transaction runs a right-to-left square-and-multiply over the
// exponent. Every modular multiply goes through one shared bit-serial unit
// that scans MW = max(WIDTH, 16) multiplier bits: a base reduction, then one
// square per exponent bit up to its top set bit plus one multiply per set bit.
// A modulus below two answers 0 in the next cycle.
// Reset is synchronous, active low, and restores the register defaults.
// Results cannot be stalled; the next transaction may start while one shows.
module rsa_modular_exponentiation #(
  parameter int WIDTH = rsa_mexp_pkg::WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_op,
  input  logic [rsa_mexp_pkg::DATA_W-1:0]      in_value,
  output logic                                 out_valid,
  output logic [rsa_mexp_pkg::DATA_W-1:0]      out_result_value,
  input  logic                                 cfg_we,
  input  logic [rsa_mexp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsa_mexp_pkg::DATA_W-1:0]      cfg_data
);

  localparam int MW = (WIDTH > rsa_mexp_pkg::DATA_W) ? WIDTH : rsa_mexp_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // wait for a transaction
    S_RED  = 4'b0010,  // reduce base modulo modulus
    S_MUL  = 4'b0100,  // res = res * sq mod m
    S_SQR  = 4'b1000   // sq = sq * sq mod m
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [WIDTH-1:0] mod_r, mod_nxt;
  logic [WIDTH-1:0] pub_r, pub_nxt;
  logic [WIDTH-1:0] priv_r, priv_nxt;

  // Exponentiation working registers
  logic [WIDTH-1:0] exp_r, exp_nxt;
  logic [WIDTH-1:0] sq_r, sq_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;

  // Multiplier launch
  logic             mm_start_r, mm_start_nxt;
  logic [WIDTH-1:0] mm_a_r, mm_a_nxt;
  logic [MW-1:0]    mm_b_r, mm_b_nxt;
  logic             mm_done;
  logic [WIDTH-1:0] mm_prod;

  // Result register
  logic                            out_valid_r, out_valid_nxt;
  logic [rsa_mexp_pkg::DATA_W-1:0] out_value_r, out_value_nxt;

  // Shared step decision after a square (or after base reduction)
  logic             go_step;
  logic [WIDTH-1:0] st_exp, st_res, st_sq;

  rsa_mexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mm_start_r),
    .a_i     (mm_a_r),
    .b_i     (mm_b_r),
    .m_i     (mod_r),
    .done_o  (mm_done),
    .prod_o  (mm_prod)
  );

  // Configuration writes; indexes beyond the list are dropped
  always_comb begin
    mod_nxt  = mod_r;
    pub_nxt  = pub_r;
    priv_nxt = priv_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rsa_mexp_pkg::REG_MODULUS:  mod_nxt  = WIDTH'(cfg_data);
        rsa_mexp_pkg::REG_PUB_EXP:  pub_nxt  = WIDTH'(cfg_data);
        rsa_mexp_pkg::REG_PRIV_EXP: priv_nxt = WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    mm_start_nxt  = 1'b0;
    mm_a_nxt      = mm_a_r;
    mm_b_nxt      = mm_b_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    go_step       = 1'b0;
    st_exp        = exp_r;
    st_res        = res_r;
    st_sq         = sq_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (mod_r < WIDTH'(2)) begin
            // Degenerate modulus: answer zero at once
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
          end else begin
            exp_nxt      = (in_op == rsa_mexp_pkg::OP_DECRYPT) ? priv_r : pub_r;
            // Reduce the base as 1 * base mod m
            mm_start_nxt = 1'b1;
            mm_a_nxt     = WIDTH'(1);
            mm_b_nxt     = (in_op == rsa_mexp_pkg::OP_ENCRYPT) ? MW'(in_value[7:0])
                                                                : MW'(in_value);
            state_nxt    = S_RED;
          end
        end
      end
      S_RED: begin
        if (mm_done) begin
          sq_nxt  = mm_prod;
          res_nxt = WIDTH'(1);
          go_step = 1'b1;
          st_exp  = exp_r;
          st_res  = WIDTH'(1);
          st_sq   = mm_prod;
        end
      end
      S_MUL: begin
        if (mm_done) begin
          res_nxt      = mm_prod;
          mm_start_nxt = 1'b1;
          mm_a_nxt     = sq_r;
          mm_b_nxt     = MW'(sq_r);
          state_nxt    = S_SQR;
        end
      end
      S_SQR: begin
        if (mm_done) begin
          sq_nxt  = mm_prod;
          exp_nxt = exp_r >> 1;
          go_step = 1'b1;
          st_exp  = exp_r >> 1;
          st_res  = res_r;
          st_sq   = mm_prod;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Advance to the next exponent bit, or finish when none are left
    if (go_step) begin
      if (st_exp == '0) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rsa_mexp_pkg::DATA_W'(st_res);
        state_nxt     = S_IDLE;
      end else if (st_exp[0]) begin
        mm_start_nxt = 1'b1;
        mm_a_nxt     = st_res;
        mm_b_nxt     = MW'(st_sq);
        state_nxt    = S_MUL;
      end else begin
        mm_start_nxt = 1'b1;
        mm_a_nxt     = st_sq;
        mm_b_nxt     = MW'(st_sq);
        state_nxt    = S_SQR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= WIDTH'(2);
      pub_r       <= WIDTH'(1);
      priv_r      <= WIDTH'(1);
      mm_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      pub_r       <= pub_nxt;
      priv_r      <= priv_nxt;
      mm_start_r  <= mm_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    exp_r       <= exp_nxt;
    sq_r        <= sq_nxt;
    res_r       <= res_nxt;
    mm_a_r      <= mm_a_nxt;
    mm_b_r      <= mm_b_nxt;
    out_value_r <= out_value_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;

  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (mod_r >= WIDTH'(2))) |=> busy)
    else $error("accepted transaction did not start exponentiation");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> (state_r != S_IDLE))
    else $error("multiplier result arrived while idle");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

endmodule
